// ===== sv/rlob_pkg.sv =====
`timescale 1ns / 1ps
// rlob_pkg: shared types, register codes and arithmetic helpers for the
// rgba layer over-blend core. No dependencies.

package rlob_pkg;

  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned NUM_W     = 24;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE     = 1'd1;

  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_ERASE,
    SEL_COPY,
    SEL_BLEND
  } sel_e;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [7:0]       quo;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_CH-1:0] lane;
    logic [DEN_W-1:0]   den;
    logic               blend;
    logic               written;
    logic [31:0]        px;
  } div_t;

  // floor(x / 255), exact for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // x * 255 as shift and subtract
  function automatic logic [23:0] mul255(input logic [15:0] x);
    return {x, 8'h00} - {8'h00, x};
  endfunction

  // one restoring division step on every channel
  function automatic div_t div_step(input div_t x, input int unsigned bit_pos);
    div_t             y;
    logic [NUM_W-1:0] sh;
    y  = x;
    sh = NUM_W'(x.den) << bit_pos;
    for (int c = 0; c < NUM_CH; c++) begin
      if (x.lane[c].rem >= sh) begin
        y.lane[c].rem          = x.lane[c].rem - sh;
        y.lane[c].quo[bit_pos] = 1'b1;
      end
    end
    return y;
  endfunction

endpackage

// ===== sv/rgba_layer_over_blend_core.sv =====
`timescale 1ns / 1ps
// rgba_layer_over_blend_core: pipelined straight-alpha rgba8888 layer merge
// (transparent keep, erase, copy and over blend). Uses rlob_pkg.

// Takes one source/destination pixel pair per clock and returns one merged
// word per clock unless the output stalls. Three stages form the products,
// weighted sums and the alpha, then an eight-stage restoring divider resolves
// one quotient bit per stage for red, green and blue in parallel, then the
// output register. Stalls on the output back up through the pipeline without
// loss, and empty stages are filled while the output is stalled.
// Configuration writes are taken at any time (ready is always high) and must
// only happen while the pipeline is empty.

module rgba_layer_over_blend_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlob_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   src_pixel_i,
  input  logic [31:0]                   dst_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   merged_pixel_o,
  output logic                          was_written_o
);

  localparam int unsigned NCh = rlob_pkg::NUM_CH;
  localparam int unsigned NDv = rlob_pkg::DIV_STEPS;

  // config registers
  logic ovr_q, ers_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_q <= 1'b0;
      ers_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rlob_pkg::CFG_OVERWRITE: ovr_q <= cfg_data_i;
        rlob_pkg::CFG_ERASE:     ers_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control
  logic            v_a_q, v_b_q, v_c_q, out_valid_q;
  logic [NDv-1:0]  v_d_q;
  logic            ld_a, ld_b, ld_c, ld_out;
  logic [NDv-1:0]  ld_d;

  always_comb begin
    ld_out       = !out_valid_q || !out_stall_i;
    ld_d[NDv-1]  = !v_d_q[NDv-1] || ld_out;
    for (int i = NDv - 2; i >= 0; i--) begin
      ld_d[i] = !v_d_q[i] || ld_d[i+1];
    end
    ld_c = !v_c_q || ld_d[0];
    ld_b = !v_b_q || ld_c;
    ld_a = !v_a_q || ld_b;
  end

  assign in_stall_o = !ld_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q       <= 1'b0;
      v_b_q       <= 1'b0;
      v_c_q       <= 1'b0;
      v_d_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld_a) v_a_q <= in_valid_i;
      if (ld_b) v_b_q <= v_a_q;
      if (ld_c) v_c_q <= v_b_q;
      if (ld_d[0]) v_d_q[0] <= v_c_q;
      for (int i = 1; i < NDv; i++) begin
        if (ld_d[i]) v_d_q[i] <= v_d_q[i-1];
      end
      if (ld_out) out_valid_q <= v_d_q[NDv-1];
    end
  end

  // stage a: case select and first products
  logic [7:0]              sa, da, inv;
  rlob_pkg::sel_e          sel_d;
  logic [NCh-1:0][15:0]    pss_d;
  logic [15:0]             pdi_d;

  rlob_pkg::sel_e          a_sel_q;
  logic [31:0]             a_src_q, a_dst_q;
  logic [7:0]              a_sa_q;
  logic [NCh-1:0][15:0]    a_pss_q;
  logic [15:0]             a_pdi_q;

  always_comb begin
    sa  = src_pixel_i[7:0];
    da  = dst_pixel_i[7:0];
    inv = 8'hFF - sa;
    if (sa == 8'h00) begin
      sel_d = rlob_pkg::SEL_KEEP;
    end else if (ers_q) begin
      sel_d = rlob_pkg::SEL_ERASE;
    end else if (sa == 8'hFF || ovr_q) begin
      sel_d = rlob_pkg::SEL_COPY;
    end else begin
      sel_d = rlob_pkg::SEL_BLEND;
    end
    for (int c = 0; c < NCh; c++) begin
      pss_d[c] = 16'(src_pixel_i[8*c+8 +: 8]) * 16'(sa);
    end
    pdi_d = 16'(da) * 16'(inv);
  end

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_sel_q <= sel_d;
      a_src_q <= src_pixel_i;
      a_dst_q <= dst_pixel_i;
      a_sa_q  <= sa;
      a_pss_q <= pss_d;
      a_pdi_q <= pdi_d;
    end
  end

  // stage b: weighted terms, combined alpha, erase alpha
  logic [NCh-1:0][23:0]    sw_d, dw_d;
  logic [15:0]             den_d;

  rlob_pkg::sel_e          b_sel_q;
  logic [31:0]             b_src_q, b_dst_q;
  logic [NCh-1:0][23:0]    b_sw_q, b_dw_q;
  logic [15:0]             b_den_q;
  logic [7:0]              b_ae_q;

  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      sw_d[c] = rlob_pkg::mul255(a_pss_q[c]);
      dw_d[c] = 24'(a_dst_q[8*c+8 +: 8]) * 24'(a_pdi_q);
    end
    den_d = {a_sa_q, 8'h00} - {8'h00, a_sa_q} + a_pdi_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      b_sel_q <= a_sel_q;
      b_src_q <= a_src_q;
      b_dst_q <= a_dst_q;
      b_sw_q  <= sw_d;
      b_dw_q  <= dw_d;
      b_den_q <= den_d;
      b_ae_q  <= rlob_pkg::div255(a_pdi_q);
    end
  end

  // stage c: numerators and the word for the non-divided cases
  logic [NCh-1:0][24:0]    num_d;
  logic [31:0]             px_d;
  rlob_pkg::div_t          c_q;

  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      num_d[c] = 25'(b_sw_q[c]) + 25'(b_dw_q[c]);
    end
    case (b_sel_q)
      rlob_pkg::SEL_KEEP:  px_d = b_dst_q;
      rlob_pkg::SEL_ERASE: px_d = {b_dst_q[31:8], b_ae_q};
      rlob_pkg::SEL_COPY:  px_d = b_src_q;
      rlob_pkg::SEL_BLEND: px_d = {24'h000000, rlob_pkg::div255(b_den_q)};
      default:             px_d = b_src_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_c) begin
      for (int c = 0; c < NCh; c++) begin
        c_q.lane[c].rem <= num_d[c][rlob_pkg::NUM_W-1:0];
        c_q.lane[c].quo <= 8'h00;
      end
      c_q.den     <= b_den_q;
      c_q.blend   <= (b_sel_q == rlob_pkg::SEL_BLEND);
      c_q.written <= (b_sel_q != rlob_pkg::SEL_KEEP);
      c_q.px      <= px_d;
    end
  end

  // divider: one quotient bit per stage, msb first
  rlob_pkg::div_t d_q [NDv];

  for (genvar i = 0; i < NDv; i++) begin : g_div
    localparam int unsigned BitPos = NDv - 1 - i;
    rlob_pkg::div_t prev;
    if (i == 0) begin : g_first
      assign prev = c_q;
    end else begin : g_next
      assign prev = d_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (ld_d[i]) begin
        d_q[i] <= rlob_pkg::div_step(prev, BitPos);
      end
    end
  end

  // output register
  rlob_pkg::div_t last;
  logic [31:0]    out_px_d;
  logic [31:0]    out_px_q;
  logic           out_wr_q;

  assign last     = d_q[NDv-1];
  assign out_px_d = last.blend ?
                    {last.lane[2].quo, last.lane[1].quo, last.lane[0].quo, last.px[7:0]} :
                    last.px;

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_px_q <= out_px_d;
      out_wr_q <= last.written;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_pixel_o = out_px_q;
  assign was_written_o  = out_wr_q;

endmodule

// ===== sv/rlob_chk.sv =====
`timescale 1ns / 1ps
// rlob_chk: port-level assertions for rgba_layer_over_blend_core, bound to
// the top level. Depends on rlob_pkg and the top-level port list.

module rlob_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [rlob_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic                           cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [31:0]                    src_pixel_i,
  input logic [31:0]                    dst_pixel_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [31:0]                    merged_pixel_o,
  input logic                           was_written_o
);

  localparam int unsigned Lat   = 12;
  localparam logic [3:0]  Steps = 4'(Lat - 1);

  // consecutive cycles with the output not stalled
  logic [3:0] calm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm_q <= '0;
    end else if (out_stall_i) begin
      calm_q <= '0;
    end else if (calm_q != 4'hF) begin
      calm_q <= calm_q + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(merged_pixel_o) && $stable(was_written_o))
    else $error("output word changed while stalled");

  a_no_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with free-running output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && !in_stall_o, Lat) && calm_q >= Steps |-> out_valid_o)
    else $error("word missing after pipeline latency");

  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && !in_stall_o && src_pixel_i[7:0] == 8'h00, Lat) &&
    calm_q >= Steps |->
    !was_written_o && merged_pixel_o == $past(dst_pixel_i, Lat))
    else $error("transparent source did not pass destination");

endmodule

bind rgba_layer_over_blend_core rlob_chk u_rlob_chk (.*);
